// File: design/jqs_pkg.sv
`timescale 1ns / 1ps
package jqs_pkg;

  localparam int TRY_LIMIT_DEF = 30;

  localparam logic [31:0] Q_START = 32'h0000_0040;
  localparam logic [31:0] Q_FIFTY = 32'd50 << 10;
  localparam logic [31:0] Q_SEVENTY = 32'd70 << 10;
  localparam logic [31:0] Q_FORCED = 32'd10;
  localparam logic [31:0] GAP_RESET = 32'h00FF_FFFF;
  localparam logic [4:0] SHIFT_RESET = 5'd10;
  localparam logic [4:0] TRIES_RESET = 5'd30;

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_SHIFT  = 2'd1,
    REG_TRIES  = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OC_CONT      = 4'd0,
    OC_IN_RANGE  = 4'd1,
    OC_LOWEST    = 4'd2,
    OC_SATURATED = 4'd3,
    OC_ZERO_DIV  = 4'd4,
    OC_BEST      = 4'd5,
    OC_LIMIT     = 4'd6,
    OC_EXHAUSTED = 4'd7,
    OC_ERROR     = 4'd8
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMUL,
    ST_EVAL,
    ST_SPREP,
    ST_SMUL,
    ST_SDIV,
    ST_TAIL,
    ST_FIN
  } state_t;

endpackage

// File: design/jpeg_quality_search.sv
`timescale 1ns / 1ps
// Channel  Handshake           Payload
// in       in_valid/in_ready   command, code_size, err_ratio, encode_failed
// out      out_valid/out_ready next_quality, done_res, outcome, try_index
// cfg      cfg_we              cfg_index, cfg_data
//
// A start beat goes from idle straight to the result stage. A trial beat runs a
// 16-step serial ratio multiply and, when the secant step runs, then
// a 32-step shift-add multiplier and a 64-step restoring divider.
// Reset (rst, synchronous) clears the search and loads register defaults.
// Input is taken only in the idle state; a finished result waits in the
// output register while out_ready is low and holds the next result back.
module jpeg_quality_search #(
  parameter int TRY_LIMIT = jqs_pkg::TRY_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] code_size,
  input  logic [15:0] err_ratio,
  input  logic        encode_failed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_quality,
  output logic        done_res,
  output logic [3:0]  outcome,
  output logic [4:0]  try_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import jqs_pkg::*;

  localparam logic [4:0] LIMIT = 5'(TRY_LIMIT);

  state_t state, state_next;

  // configuration
  logic [30:0] target;
  logic [4:0]  shift;
  logic [4:0]  tries;

  // search state
  logic [4:0]  try_cnt;
  logic [31:0] cur_q, lq, hq, ls, hs, best_q, best_gap, prev_sz;
  logic        hrf, active;

  // work registers
  logic [31:0] sz;
  logic [63:0] acc;
  logic [31:0] amag, dmag, rem;
  logic        neg, post_lim;
  logic [6:0]  cnt;

  // staged result
  logic [31:0] res_q;
  logic        res_done;
  outcome_t    res_oc;
  logic [4:0]  res_idx;

  logic [4:0]  eff;
  logic [31:0] tgt;
  logic        fire, out_free;

  assign eff = (tries < LIMIT) ? tries : LIMIT;
  assign tgt = {1'b0, target};
  assign fire = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // trial evaluation
  logic        lt, gt, inrange, sat1, sat2, lim;
  logic [31:0] gap, win, lq_u, ls_u, hq_u, hs_u, bq_u, bg_u;
  logic        ev_emit, ev_sec, ev_lim;
  logic [31:0] ev_q;
  outcome_t    ev_oc;

  always_comb begin
    lt = sz < tgt;
    gt = tgt < sz;
    gap = tgt - sz;
    win = 32'($signed(prev_sz) >>> 7);
    inrange = !lt && (sz < tgt + {6'd0, target[30:6]});
    sat1 = ($signed(prev_sz - win) < $signed(sz)) && ($signed(prev_sz + win) > $signed(sz))
           && lt;
    sat2 = (prev_sz == sz) && lt;
    lim = ({2'd0, try_cnt} + 7'd2) >= {2'd0, eff};
    lq_u = lq;
    ls_u = ls;
    hq_u = hq;
    hs_u = hs;
    bq_u = best_q;
    bg_u = best_gap;
    if (lt) begin
      if (best_gap > gap) begin
        bg_u = gap;
        bq_u = cur_q;
      end
      lq_u = cur_q;
      ls_u = sz;
    end else begin
      hq_u = cur_q;
      hs_u = sz;
    end
    ev_emit = 1'b0;
    ev_sec = 1'b0;
    ev_lim = 1'b0;
    ev_q = cur_q;
    ev_oc = OC_CONT;
    if (try_cnt == 5'd0) begin
      if (gt) begin
        ev_emit = 1'b1;
        ev_oc = OC_LOWEST;
      end else begin
        ev_q = Q_FIFTY;
      end
    end else if (try_cnt == 5'd1) begin
      if (lt) begin
        ev_q = Q_SEVENTY;
      end else if (sz == ls) begin
        ev_emit = 1'b1;
        ev_oc = OC_ZERO_DIV;
      end else begin
        ev_sec = 1'b1;
      end
    end else begin
      if (inrange) begin
        ev_emit = 1'b1;
        ev_oc = OC_IN_RANGE;
      end else if (sat1 || sat2) begin
        ev_emit = 1'b1;
        ev_oc = OC_SATURATED;
      end else if (hs_u == ls_u) begin
        ev_emit = 1'b1;
        ev_oc = OC_ZERO_DIV;
      end else if (lim && bq_u != 32'd0) begin
        ev_emit = 1'b1;
        ev_oc = OC_BEST;
        ev_q = bq_u;
      end else begin
        ev_sec = 1'b1;
        ev_lim = lim;
      end
    end
  end

  // secant operands and serial steps
  logic [31:0] da, db, dd;
  logic [32:0] mul_up, div_t;
  logic [31:0] qsec;
  logic [48:0] rmul_up;

  always_comb begin
    da = tgt - ls;
    db = hq - lq;
    dd = hs - ls;
    mul_up = {1'b0, acc[63:32]} + (acc[0] ? {1'b0, amag} : 33'd0);
    div_t = {rem, acc[63]};
    qsec = (neg ? (32'd0 - acc[31:0]) : acc[31:0]) + lq;
    rmul_up = {16'd0, 1'b0, acc[47:16]} + (acc[0] ? {17'd0, sz} : 49'd0);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (fire) begin
          if (!command || encode_failed) state_next = active || !command ? ST_FIN : ST_IDLE;
          else if (active) state_next = ST_RMUL;
        end
      end
      ST_RMUL:  if (cnt == 7'd15) state_next = ST_EVAL;
      ST_EVAL:  state_next = ev_emit ? ST_FIN : (ev_sec ? ST_SPREP : ST_TAIL);
      ST_SPREP: state_next = ST_SMUL;
      ST_SMUL:  if (cnt == 7'd31) state_next = ST_SDIV;
      ST_SDIV:  if (cnt == 7'd63) state_next = ST_TAIL;
      ST_TAIL:  state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      shift <= SHIFT_RESET;
      tries <= TRIES_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET: target <= cfg_data;
        REG_SHIFT:  shift <= cfg_data[4:0];
        REG_TRIES:  tries <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      try_cnt <= '0;
      cur_q <= '0;
      lq <= '0;
      hq <= '0;
      ls <= '0;
      hs <= '0;
      best_q <= '0;
      best_gap <= GAP_RESET;
      prev_sz <= '0;
      hrf <= 1'b0;
      active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FIN) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (fire && !command) begin
            try_cnt <= '0;
            hq <= '0;
            ls <= '0;
            hs <= '0;
            best_q <= '0;
            best_gap <= GAP_RESET;
            prev_sz <= '0;
            hrf <= 1'b0;
            res_idx <= '0;
            if (eff == 5'd0) begin
              cur_q <= '0;
              lq <= '0;
              active <= 1'b0;
              res_q <= '0;
              res_done <= 1'b1;
              res_oc <= OC_EXHAUSTED;
            end else begin
              cur_q <= Q_START;
              lq <= Q_START;
              active <= 1'b1;
              res_q <= Q_START;
              res_done <= 1'b0;
              res_oc <= OC_CONT;
            end
          end else if (fire && active) begin
            res_idx <= try_cnt;
            if (encode_failed) begin
              res_q <= cur_q;
              res_done <= 1'b1;
              res_oc <= OC_ERROR;
              active <= 1'b0;
            end else begin
              sz <= code_size >> shift;
              acc <= {48'd0, err_ratio};
            end
          end
        end
        // shift-add the ratio into the size, one ratio bit a cycle
        ST_RMUL: begin
          acc <= {16'd0, rmul_up[32:0], acc[15:1]};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd15) sz <= {rmul_up[24:0], acc[15:9]};
        end
        ST_EVAL: begin
          prev_sz <= sz;
          cnt <= '0;
          post_lim <= ev_lim;
          res_q <= ev_q;
          res_oc <= ev_oc;
          if (ev_emit) begin
            res_done <= 1'b1;
            active <= 1'b0;
          end
          if (try_cnt == 5'd0) begin
            if (!gt) begin
              ls <= sz;
              hq <= Q_FIFTY;
            end
          end else if (try_cnt == 5'd1) begin
            if (lt) hrf <= 1'b1;
            else hs <= sz;
          end else begin
            lq <= lq_u;
            ls <= ls_u;
            hq <= hq_u;
            hs <= hs_u;
            best_q <= bq_u;
            best_gap <= bg_u;
          end
        end
        // take magnitudes and the quotient sign
        ST_SPREP: begin
          amag <= da[31] ? 32'd0 - da : da;
          acc <= {32'd0, db[31] ? 32'd0 - db : db};
          dmag <= dd[31] ? 32'd0 - dd : dd;
          neg <= da[31] ^ db[31] ^ dd[31];
          rem <= '0;
        end
        ST_SMUL: begin
          acc <= {mul_up, acc[31:1]};
          cnt <= (cnt == 7'd31) ? 7'd0 : cnt + 7'd1;
        end
        // restoring division, one quotient bit a cycle
        ST_SDIV: begin
          cnt <= cnt + 7'd1;
          if (div_t >= {1'b0, dmag}) begin
            rem <= 32'(div_t - {1'b0, dmag});
            acc <= {acc[62:0], 1'b1};
          end else begin
            rem <= div_t[31:0];
            acc <= {acc[62:0], 1'b0};
          end
          if (cnt == 7'd63) res_q <= 32'd0;
        end
        // commit the next quality and, unless the try limit ends the search, advance the trial count
        ST_TAIL: begin
          begin : tail_blk
            logic [31:0] qv;
            logic        fin6;
            qv = res_q;
            fin6 = 1'b0;
            if (cnt == 7'd64) begin
              qv = qsec;
              if (post_lim) begin
                if (lt) fin6 = 1'b1;
                else qv = Q_FORCED;
              end
            end
            res_q <= qv;
            if (fin6) begin
              res_done <= 1'b1;
              res_oc <= OC_LIMIT;
              active <= 1'b0;
            end else begin
              cur_q <= qv;
              try_cnt <= try_cnt + 5'd1;
              if ({1'b0, try_cnt} + 6'd1 >= {1'b0, eff}) begin
                res_done <= 1'b1;
                res_oc <= OC_EXHAUSTED;
                active <= 1'b0;
              end else begin
                res_done <= 1'b0;
                res_oc <= OC_CONT;
              end
            end
          end
        end
        // hand the result to the output register
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            next_quality <= res_q;
            done_res <= res_done;
            outcome <= res_oc;
            try_index <= res_idx;
          end
        end
        default: ;
      endcase
    end
  end

  ap_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SDIV) |-> (dmag != 32'd0))
    else $error("divider running with zero divisor");

  ap_start_fin: assert property (@(posedge clk) disable iff (rst)
    (fire && !command) |=> (state == ST_FIN))
    else $error("start beat did not stage a result");

  ap_fin_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("staged result not loaded");

  ap_done_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (outcome != OC_CONT))
    else $error("finished result carries continue code");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import jqs_pkg::*;

  localparam int ITEM_GOAL = 1450;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 160;

  typedef struct packed {
    logic [31:0] quality;
    logic        done;
    outcome_t    oc;
    logic [4:0]  idx;
  } quality_res_t;

  typedef struct {
    bit          cmd;
    logic [31:0] csize;
    logic [15:0] ratio;
    bit          fail;
    bit          typed;
    logic [31:0] quality;
    bit          done;
    outcome_t    oc;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [31:0] code_size = '0;
  logic [15:0] err_ratio = '0;
  logic        encode_failed = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] next_quality;
  logic        done_res;
  logic [3:0]  outcome;
  logic [4:0]  try_index;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_NONE;
  logic [30:0] cfg_data = '0;

  // search state mirrored from the block
  logic [31:0] tgt_bytes, shift_amt, tries_max;
  logic [31:0] try_cnt, cur_q, lo_q, hi_q, lo_size, hi_size, best_q, best_gap, prev_size;
  bit          search_on;

  quality_res_t expected_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          results_due = 0;
  int          items_sent = 0;
  bit          quiet = 1'b0;
  bit          squeeze = 1'b0;

  jpeg_quality_search i_dut (.*);

  always #10 clk = ~clk;

  // guard against a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic logic [31:0] budget();
    return (tries_max < 30) ? tries_max : 32'd30;
  endfunction

  function automatic void clear_search();
    try_cnt = 0; cur_q = 0; lo_q = 0; hi_q = 0; lo_size = 0; hi_size = 0;
    best_q = 0; best_gap = GAP_RESET; prev_size = 0; search_on = 1'b0;
  endfunction

  function automatic logic [31:0] secant_q();
    longint a, b, d, q64;
    logic [31:0] t;
    t = tgt_bytes - lo_size; a = longint'($signed(t));
    t = hi_q - lo_q;         b = longint'($signed(t));
    t = hi_size - lo_size;   d = longint'($signed(t));
    q64 = (a * b) / d;
    return q64[31:0] + lo_q;
  endfunction

  function automatic quality_res_t finish(input logic [31:0] q, input outcome_t oc,
                                          input logic [31:0] r);
    search_on = 1'b0;
    return '{q, 1'b1, oc, r[4:0]};
  endfunction

  // work out the result of one beat; returns 0 when the beat is ignored
  function automatic bit predict_quality(input bit cmd, input logic [31:0] csize,
                                         input logic [15:0] ratio, input bit fail,
                                         output quality_res_t res);
    logic [31:0] r, size, q, tgt, prev, win;
    logic [47:0] prod;
    if (!cmd) begin
      clear_search();
      if (budget() == 0) begin
        res = '{32'd0, 1'b1, OC_EXHAUSTED, 5'd0};
        return 1;
      end
      cur_q = Q_START; lo_q = Q_START; search_on = 1'b1;
      res = '{Q_START, 1'b0, OC_CONT, 5'd0};
      return 1;
    end
    if (!search_on) return 0;
    r = try_cnt; q = cur_q; tgt = tgt_bytes;
    if (fail) begin
      res = finish(q, OC_ERROR, r);
      return 1;
    end
    size = csize >> shift_amt[4:0];
    if (ratio != 16'h0100) begin
      prod = size * ratio;
      size = prod[39:8];
    end
    prev = prev_size;
    prev_size = size;
    if (r == 0) begin
      if (tgt < size) begin
        res = finish(q, OC_LOWEST, r);
        return 1;
      end
      lo_size = size; q = Q_FIFTY; hi_q = q;
    end else if (r == 1) begin
      if (tgt > size) q = Q_SEVENTY;
      else begin
        hi_size = size;
        if (hi_size == lo_size) begin
          res = finish(q, OC_ZERO_DIV, r);
          return 1;
        end
        q = secant_q();
      end
    end else begin
      if (tgt > size) begin
        if (best_gap > tgt - size) begin
          best_gap = tgt - size; best_q = q;
        end
        lo_q = q; lo_size = size;
      end else begin
        hi_q = q; hi_size = size;
      end
      if (size >= tgt && size < tgt + (tgt >> 6)) begin
        res = finish(q, OC_IN_RANGE, r);
        return 1;
      end
      win = $signed(prev) >>> 7;
      if ($signed(prev - win) < $signed(size) && $signed(prev + win) > $signed(size)
          && size < tgt) begin
        res = finish(q, OC_SATURATED, r);
        return 1;
      end
      if (prev == size && size < tgt) begin
        res = finish(q, OC_SATURATED, r);
        return 1;
      end
      if (hi_size == lo_size) begin
        res = finish(q, OC_ZERO_DIV, r);
        return 1;
      end
      q = secant_q();
      if (int'(r) >= int'(budget()) - 2) begin
        if (best_q != 0) begin
          res = finish(best_q, OC_BEST, r);
          return 1;
        end
        if (size < tgt) begin
          res = finish(q, OC_LIMIT, r);
          return 1;
        end
        q = Q_FORCED;
      end
    end
    cur_q = q;
    try_cnt = (r + 1) & 32'h1F;
    if (r + 1 >= budget()) begin
      res = finish(q, OC_EXHAUSTED, r);
      return 1;
    end
    res = '{q, 1'b0, OC_CONT, r[4:0]};
    return 1;
  endfunction

  // drive one beat, wait for acceptance and queue its expectation
  task automatic send_beat(input bit cmd, input logic [31:0] csize, input logic [15:0] ratio,
                           input bit fail, input bit typed = 0, input quality_res_t typed_res = '0);
    quality_res_t res;
    in_valid = 1'b1; command = cmd; code_size = csize; err_ratio = ratio;
    encode_failed = fail;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    items_sent++;
    if (predict_quality(cmd, csize, ratio, fail, res)) begin
      expected_q.push_back(typed ? typed_res : res);
      results_due++;
    end
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // write a register once the block has gone quiet
  task automatic write_reg(input cfg_reg_t idx, input logic [30:0] val);
    in_valid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    case (idx)
      REG_TARGET: tgt_bytes = {1'b0, val};
      REG_SHIFT:  shift_amt = 32'(val[4:0]);
      REG_TRIES:  tries_max = 32'(val[4:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0; cfg_index = REG_NONE;
  endtask

  // receiver: random stall bursts, one long hold-off to back the block up
  initial begin
    bit squeezed;
    squeezed = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1;
        out_ready = 1'b0;
        repeat (600) @(negedge clk);
      end
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    quality_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) report("result beat with nothing expected");
      else begin
        e = expected_q.pop_front();
        if (next_quality !== e.quality)
          report($sformatf("next_quality %h, want %h", next_quality, e.quality));
        if (done_res !== e.done)
          report($sformatf("done_res %b, want %b", done_res, e.done));
        if (outcome !== e.oc)
          report($sformatf("outcome %0d, want %0d", outcome, e.oc));
        if (try_index !== e.idx)
          report($sformatf("try_index %0d, want %0d", try_index, e.idx));
      end
    end
  end

  // scaled size near the target, turned back into a raw code size
  function automatic logic [31:0] raw_near(input logic [31:0] tgt, input logic [4:0] sh);
    logic [31:0] spread, s;
    spread = (tgt >> $urandom_range(1, 6)) + 2;
    case ($urandom_range(0, 5))
      0: s = tgt;
      1: s = tgt + $urandom_range(0, tgt >> 6);
      default: s = $urandom_range(0, 1) ? tgt + $urandom_range(0, spread)
                                        : tgt - $urandom_range(0, spread);
    endcase
    return (s << sh) | ($urandom() & ((32'd1 << sh) - 1));
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    logic [30:0] tgt_pick;
    int phase, trials;
    tgt_bytes = 0; shift_amt = 32'(SHIFT_RESET); tries_max = 32'(TRIES_RESET);
    clear_search();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed rows under the reset settings (target 0)
    rows = '{
      '{1'b0, 32'd0,        16'h0100, 1'b0, 1'b1, Q_START, 1'b0, OC_CONT},
      '{1'b1, 32'd0,        16'h0100, 1'b1, 1'b1, Q_START, 1'b1, OC_ERROR},
      '{1'b1, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 1'b0, 0, 0, OC_CONT},
      '{1'b0, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 1'b1, Q_START, 1'b0, OC_CONT},
      '{1'b1, 32'hFFFFFFFF, 16'h0100, 1'b0, 1'b1, Q_START, 1'b1, OC_LOWEST},
      '{1'b0, 32'd0,        16'h0000, 1'b0, 1'b1, Q_START, 1'b0, OC_CONT},
      '{1'b1, 32'd1023,     16'h0100, 1'b0, 1'b0, 0, 0, OC_CONT},
      '{1'b1, 32'd1023,     16'h0100, 1'b0, 1'b0, 0, 0, OC_CONT},
      '{1'b0, 32'd0,        16'h0100, 1'b0, 1'b1, Q_START, 1'b0, OC_CONT},
      '{1'b1, 32'd0,        16'h0000, 1'b0, 1'b0, 0, 0, OC_CONT},
      '{1'b1, 32'h00000400, 16'hFFFF, 1'b0, 1'b0, 0, 0, OC_CONT},
      '{1'b1, 32'd0,        16'h0100, 1'b0, 1'b0, 0, 0, OC_CONT},
      '{1'b1, 32'd2048,     16'h0080, 1'b0, 1'b0, 0, 0, OC_CONT},
      '{1'b1, 32'd4096,     16'h0100, 1'b1, 1'b0, 0, 0, OC_CONT}
    };
    foreach (rows[i]) begin
      row = rows[i];
      send_beat(row.cmd, row.csize, row.ratio, row.fail, row.typed,
                '{row.quality, row.done, row.oc, 5'd0});
    end

    // zero budget finishes at once
    write_reg(REG_TRIES, 31'd0);
    send_beat(1'b0, 32'd0, 16'h0100, 1'b0, 1'b1, '{32'd0, 1'b1, OC_EXHAUSTED, 5'd0});
    send_beat(1'b1, 32'd0, 16'h0100, 1'b0);

    // random phases, each under fresh settings
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase % 6)
        0: tgt_pick = 31'h7FFFFFFF;
        1: tgt_pick = 31'd0;
        default: tgt_pick = (phase % 2) ? 31'($urandom()) : 31'($urandom_range(16, 200000));
      endcase
      write_reg(REG_TARGET, tgt_pick);
      case (phase % 5)
        0: write_reg(REG_SHIFT, 31'd0);
        1: write_reg(REG_SHIFT, 31'd31);
        default: write_reg(REG_SHIFT, 31'($urandom_range(0, 12)));
      endcase
      case (phase % 7)
        0: write_reg(REG_TRIES, 31'd31);
        1: write_reg(REG_TRIES, 31'd1);
        2: write_reg(REG_TRIES, 31'd2);
        3: write_reg(REG_TRIES, 31'd0);
        default: write_reg(REG_TRIES, 31'($urandom_range(3, 30)));
      endcase
      if (items_sent > 200) squeeze = 1'b1;
      if (items_sent > ITEM_GOAL - 150) quiet = 1'b1;
      repeat (6) begin
        if (items_sent >= ITEM_GOAL) break;
        send_beat(1'b0, $urandom(), 16'($urandom()), 1'($urandom_range(0, 1)));
        trials = $urandom_range(1, 34);
        repeat (trials) begin
          if ($urandom_range(0, 9) == 0)
            send_beat(1'b1, $urandom(), 16'($urandom()), 1'($urandom_range(0, 1)));
          else
            send_beat(1'b1, raw_near(tgt_bytes, shift_amt[4:0]),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom_range(200, 320)) : 16'h0100,
                      $urandom_range(0, 40) == 0);
        end
      end
      phase++;
    end

    in_valid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: jpeg_quality_search.f
design/jqs_pkg.sv
design/jpeg_quality_search.sv
verif/testbench.sv
